FILE: rtl/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg
// shared types and constants of the polygon area and centroid block
// ----------------------------------------------------------------------------
package pac_pkg;

  localparam int COORD_W      = 12;
  localparam int CFG_W        = 13;
  localparam int CNT_W        = 13;
  localparam int MAX_VERTICES = 4096;
  localparam int FRAC_BITS    = 8;
  localparam int FIX_W        = 20;
  localparam int AREA_W       = 26;
  localparam int CROSS_W      = 40;
  localparam int CSUM_W       = 52;
  localparam int COORD_SUM_W  = 24;
  localparam int DIV_W        = 42;
  localparam int STEP_W       = 5;
  localparam int DIV_STEPS    = FIX_W;
  localparam int INT_SHIFT    = FIX_W - FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_CLOSE,
    ST_CMAC,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_STORE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIV_CX,
    DIV_CY,
    DIV_MX,
    DIV_MY
  } div_sel_t;

  typedef enum logic {
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic     accept;
    logic     close;
    logic     mac_en;
    logic     div_load;
    logic     div_step;
    logic     div_store;
    div_sel_t div_sel;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic take_edge;
    logic multi;
    logic few;
    logic out_busy;
  } status_t;

endpackage

FILE: rtl/polygon_area_centroid.sv
// ----------------------------------------------------------------------------
// polygon_area_centroid
// shoelace area, centroid and vertex mean of a polygon streamed vertex by vertex
// ----------------------------------------------------------------------------
// vertices come in one word at a time, the last one flagged. each vertex after
// the first registers the cross product from the previous vertex, then holds
// in_stall for the multiply-accumulate of the centroid sums; the first vertex
// and vertices past the 4096 limit skip the multiply-accumulate. the flagged
// word closes the polygon: the closing edge's cross product and, past one
// vertex, its multiply-accumulate, then four divisions one after another on
// one shared restoring divider (load, a 20-bit quotient, store), then the
// result word is loaded; with fewer than three vertices no division is run.
// a finished result sits in the output register; new vertices are taken while
// it waits, and only the next polygon's emit waits for it to be taken.
// centroid and mean are unsigned q12.8, the centroid divides by the signed area
// so a clockwise or counter-clockwise order gives the same point.
// config writes (image width, image height) are always ready and should only
// be issued while no polygon is in flight.
// ----------------------------------------------------------------------------
module polygon_area_centroid (
  input  logic                        clk,
  input  logic                        rst_n,
  // vertex words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pac_pkg::COORD_W-1:0] in_vertex_x,
  input  logic [pac_pkg::COORD_W-1:0] in_vertex_y,
  input  logic                        in_last_vertex,
  // result words
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pac_pkg::AREA_W-1:0]  out_area_doubled,
  output logic [pac_pkg::FIX_W-1:0]   out_centroid_x,
  output logic [pac_pkg::FIX_W-1:0]   out_centroid_y,
  output logic [pac_pkg::FIX_W-1:0]   out_mean_x,
  output logic [pac_pkg::FIX_W-1:0]   out_mean_y,
  output logic                        out_touches_border,
  output logic                        out_too_few_vertices,
  output logic                        out_zero_area,
  output logic                        out_count_overflow,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [pac_pkg::CFG_W-1:0]   cfg_data
);

  pac_pkg::cmd_t    cmd;
  pac_pkg::status_t status;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer
  pac_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_vertex (in_last_vertex),
    .in_stall       (in_stall),
    .status         (status),
    .cmd            (cmd)
  );

  // accumulators, divider and output register
  pac_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_vertex_x          (in_vertex_x),
    .in_vertex_y          (in_vertex_y),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_area_doubled     (out_area_doubled),
    .out_centroid_x       (out_centroid_x),
    .out_centroid_y       (out_centroid_y),
    .out_mean_x           (out_mean_x),
    .out_mean_y           (out_mean_y),
    .out_touches_border   (out_touches_border),
    .out_too_few_vertices (out_too_few_vertices),
    .out_zero_area        (out_zero_area),
    .out_count_overflow   (out_count_overflow)
  );

endmodule

FILE: rtl/pac_ctrl.sv
// ----------------------------------------------------------------------------
// pac_ctrl
// sequencer: vertex accumulation, polygon close, shared divider passes, emit
// ----------------------------------------------------------------------------
module pac_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last_vertex,
  output logic             in_stall,
  input  pac_pkg::status_t status,
  output pac_pkg::cmd_t    cmd
);

  pac_pkg::state_t   state_r, state_nxt;
  pac_pkg::div_sel_t sel_r, sel_nxt;
  logic [pac_pkg::STEP_W-1:0] step_r, step_nxt;
  logic last_r, last_nxt;
  logic accept;

  assign accept   = (state_r == pac_pkg::ST_IDLE) && in_valid;
  assign in_stall = (state_r != pac_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pac_pkg::ST_IDLE;
      sel_r   <= pac_pkg::DIV_CX;
      step_r  <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      step_r  <= step_nxt;
      last_r  <= last_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    step_nxt  = step_r;
    last_nxt  = last_r;
    unique case (state_r)
      pac_pkg::ST_IDLE: begin
        if (accept) begin
          last_nxt = in_last_vertex;
          if (status.take_edge) begin
            state_nxt = pac_pkg::ST_MAC;
          end else if (in_last_vertex) begin
            state_nxt = pac_pkg::ST_CLOSE;
          end
        end
      end
      pac_pkg::ST_MAC: begin
        state_nxt = last_r ? pac_pkg::ST_CLOSE : pac_pkg::ST_IDLE;
      end
      pac_pkg::ST_CLOSE: begin
        state_nxt = status.multi ? pac_pkg::ST_CMAC : pac_pkg::ST_EMIT;
      end
      pac_pkg::ST_CMAC: begin
        sel_nxt   = pac_pkg::DIV_CX;
        state_nxt = status.few ? pac_pkg::ST_EMIT : pac_pkg::ST_DIV_LOAD;
      end
      pac_pkg::ST_DIV_LOAD: begin
        step_nxt  = '0;
        state_nxt = pac_pkg::ST_DIV_RUN;
      end
      pac_pkg::ST_DIV_RUN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == pac_pkg::STEP_W'(pac_pkg::DIV_STEPS - 1)) begin
          state_nxt = pac_pkg::ST_DIV_STORE;
        end
      end
      pac_pkg::ST_DIV_STORE: begin
        if (sel_r == pac_pkg::DIV_MY) begin
          state_nxt = pac_pkg::ST_EMIT;
        end else begin
          sel_nxt   = pac_pkg::div_sel_t'(sel_r + 1'b1);
          state_nxt = pac_pkg::ST_DIV_LOAD;
        end
      end
      pac_pkg::ST_EMIT: begin
        if (!status.out_busy) begin
          state_nxt = pac_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pac_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd           = '0;
    cmd.div_sel   = sel_r;
    cmd.accept    = accept;
    cmd.mac_en    = (state_r == pac_pkg::ST_MAC) || (state_r == pac_pkg::ST_CMAC);
    cmd.close     = (state_r == pac_pkg::ST_CLOSE);
    cmd.div_load  = (state_r == pac_pkg::ST_DIV_LOAD);
    cmd.div_step  = (state_r == pac_pkg::ST_DIV_RUN);
    cmd.div_store = (state_r == pac_pkg::ST_DIV_STORE);
    cmd.emit      = (state_r == pac_pkg::ST_EMIT) && !status.out_busy;
  end

endmodule

FILE: rtl/pac_datapath.sv
// ----------------------------------------------------------------------------
// pac_datapath
// shoelace accumulators, config registers, shared restoring divider, output
// ----------------------------------------------------------------------------
module pac_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pac_pkg::cmd_t                   cmd,
  output pac_pkg::status_t                status,
  input  logic                            cfg_valid,
  input  logic [0:0]                      cfg_index,
  input  logic [pac_pkg::CFG_W-1:0]       cfg_data,
  input  logic [pac_pkg::COORD_W-1:0]     in_vertex_x,
  input  logic [pac_pkg::COORD_W-1:0]     in_vertex_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pac_pkg::AREA_W-1:0]      out_area_doubled,
  output logic [pac_pkg::FIX_W-1:0]       out_centroid_x,
  output logic [pac_pkg::FIX_W-1:0]       out_centroid_y,
  output logic [pac_pkg::FIX_W-1:0]       out_mean_x,
  output logic [pac_pkg::FIX_W-1:0]       out_mean_y,
  output logic                            out_touches_border,
  output logic                            out_too_few_vertices,
  output logic                            out_zero_area,
  output logic                            out_count_overflow
);

  localparam int CW = pac_pkg::COORD_W;

  logic [pac_pkg::CFG_W-1:0] width_r, height_r;

  // polygon state
  logic [CW-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [pac_pkg::CNT_W-1:0] count_r;
  logic signed [pac_pkg::CROSS_W-1:0] cross_sum_r;
  logic signed [pac_pkg::CSUM_W-1:0]  cx_sum_r, cy_sum_r;
  logic [pac_pkg::COORD_SUM_W-1:0]    sum_x_r, sum_y_r;
  logic border_r, overflow_r;

  // edge pipeline
  logic signed [2*CW:0] cross_r;
  logic [CW:0] sx_r, sy_r;

  // divider
  logic [pac_pkg::DIV_W-1:0] rem_r, md_r;
  logic [pac_pkg::FIX_W-1:0] sh_r, q_r;
  logic zero_r, sat_r;
  logic [pac_pkg::FIX_W-1:0] res_r [4];

  logic out_valid_r;

  logic take;
  logic [CW-1:0] bx, by;
  logic [2*CW-1:0] p1, p2;
  logic hit;

  assign take = (count_r < pac_pkg::CNT_W'(pac_pkg::MAX_VERTICES));
  assign status.take_edge = take && (count_r != '0);
  assign status.multi     = (count_r > pac_pkg::CNT_W'(1));
  assign status.few       = (count_r < pac_pkg::CNT_W'(3));
  assign status.out_busy  = out_valid_r && out_stall;

  // end point of the edge: new vertex, or first vertex when closing
  assign bx = cmd.close ? first_x_r : in_vertex_x;
  assign by = cmd.close ? first_y_r : in_vertex_y;
  assign p1 = prev_x_r * by;
  assign p2 = bx * prev_y_r;

  assign hit = (in_vertex_x == CW'(1)) || (in_vertex_y == CW'(1))
            || ((pac_pkg::CFG_W'(in_vertex_x) + pac_pkg::CFG_W'(2)) == width_r)
            || ((pac_pkg::CFG_W'(in_vertex_y) + pac_pkg::CFG_W'(2)) == height_r);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= pac_pkg::CFG_W'(1024);
      height_r <= pac_pkg::CFG_W'(768);
    end else if (cfg_valid) begin
      if (cfg_index == pac_pkg::CFG_IMAGE_WIDTH) begin
        width_r <= cfg_data;
      end else begin
        height_r <= cfg_data;
      end
    end
  end

  // edge cross product
  always_ff @(posedge clk) begin
    if (cmd.accept || cmd.close) begin
      cross_r <= $signed({1'b0, p1}) - $signed({1'b0, p2});
      sx_r    <= {1'b0, prev_x_r} + {1'b0, bx};
      sy_r    <= {1'b0, prev_y_r} + {1'b0, by};
    end
  end

  logic signed [2*CW+CW+2:0] mac_x, mac_y;
  assign mac_x = cross_r * $signed({1'b0, sx_r});
  assign mac_y = cross_r * $signed({1'b0, sy_r});

  // accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      first_x_r   <= '0;
      first_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      count_r     <= '0;
      cross_sum_r <= '0;
      cx_sum_r    <= '0;
      cy_sum_r    <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      border_r    <= 1'b0;
      overflow_r  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (take) begin
          if (hit) begin
            border_r <= 1'b1;
          end
          sum_x_r  <= sum_x_r + pac_pkg::COORD_SUM_W'(in_vertex_x);
          sum_y_r  <= sum_y_r + pac_pkg::COORD_SUM_W'(in_vertex_y);
          if (count_r == '0) begin
            first_x_r <= in_vertex_x;
            first_y_r <= in_vertex_y;
          end
          prev_x_r <= in_vertex_x;
          prev_y_r <= in_vertex_y;
          count_r  <= count_r + 1'b1;
        end else begin
          overflow_r <= 1'b1;
        end
      end
      if (cmd.mac_en) begin
        cross_sum_r <= cross_sum_r + pac_pkg::CROSS_W'(cross_r);
        cx_sum_r    <= cx_sum_r + pac_pkg::CSUM_W'(mac_x);
        cy_sum_r    <= cy_sum_r + pac_pkg::CSUM_W'(mac_y);
      end
    end
  end

  // divider operand selection
  logic signed [pac_pkg::CSUM_W-1:0] num;
  logic signed [pac_pkg::DIV_W-1:0]  den, cross_ext;
  logic [pac_pkg::CSUM_W-1:0] mn;
  logic [pac_pkg::DIV_W-1:0]  md;
  logic [pac_pkg::CSUM_W-1:0] mn_hi;

  assign cross_ext = pac_pkg::DIV_W'(cross_sum_r);

  always_comb begin
    case (cmd.div_sel)
      pac_pkg::DIV_CX: begin
        num = cx_sum_r;
        den = (cross_ext <<< 1) + cross_ext;
      end
      pac_pkg::DIV_CY: begin
        num = cy_sum_r;
        den = (cross_ext <<< 1) + cross_ext;
      end
      pac_pkg::DIV_MX: begin
        num = $signed(pac_pkg::CSUM_W'(sum_x_r));
        den = $signed(pac_pkg::DIV_W'(count_r));
      end
      default: begin
        num = $signed(pac_pkg::CSUM_W'(sum_y_r));
        den = $signed(pac_pkg::DIV_W'(count_r));
      end
    endcase
  end

  assign mn    = num[pac_pkg::CSUM_W-1] ? pac_pkg::CSUM_W'(-num) : pac_pkg::CSUM_W'(num);
  assign md    = den[pac_pkg::DIV_W-1] ? pac_pkg::DIV_W'(-den) : pac_pkg::DIV_W'(den);
  assign mn_hi = mn >> pac_pkg::INT_SHIFT;

  // restoring step
  logic [pac_pkg::DIV_W:0] rem_sh, rem_sub;
  logic ge;
  assign rem_sh  = {rem_r, sh_r[pac_pkg::FIX_W-1]};
  assign ge      = (rem_sh >= {1'b0, md_r});
  assign rem_sub = rem_sh - {1'b0, md_r};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      md_r   <= md;
      rem_r  <= pac_pkg::DIV_W'(mn_hi);
      sh_r   <= pac_pkg::FIX_W'(mn[pac_pkg::INT_SHIFT-1:0]) << pac_pkg::FRAC_BITS;
      q_r    <= '0;
      // divisor zero, or operands of opposite sign
      zero_r <= (md == '0) || ((mn != '0)
                && (num[pac_pkg::CSUM_W-1] != den[pac_pkg::DIV_W-1]));
      sat_r  <= (mn_hi >= pac_pkg::CSUM_W'(md));
    end else if (cmd.div_step) begin
      rem_r <= ge ? rem_sub[pac_pkg::DIV_W-1:0] : rem_sh[pac_pkg::DIV_W-1:0];
      sh_r  <= sh_r << 1;
      q_r   <= {q_r[pac_pkg::FIX_W-2:0], ge};
    end
    if (cmd.div_store) begin
      res_r[cmd.div_sel] <= zero_r ? '0 : (sat_r ? '1 : q_r);
    end
  end

  // result word
  logic [pac_pkg::CROSS_W-1:0] area_mag;
  logic [pac_pkg::AREA_W-1:0]  area_sat;
  logic few;
  assign few      = status.few;
  assign area_mag = cross_sum_r[pac_pkg::CROSS_W-1] ? pac_pkg::CROSS_W'(-cross_sum_r)
                                                     : pac_pkg::CROSS_W'(cross_sum_r);
  assign area_sat = (|area_mag[pac_pkg::CROSS_W-1:pac_pkg::AREA_W]) ? '1
                                                                    : area_mag[pac_pkg::AREA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_area_doubled     <= few ? '0 : area_sat;
      out_centroid_x       <= few ? '0 : res_r[pac_pkg::DIV_CX];
      out_centroid_y       <= few ? '0 : res_r[pac_pkg::DIV_CY];
      out_mean_x           <= few ? '0 : res_r[pac_pkg::DIV_MX];
      out_mean_y           <= few ? '0 : res_r[pac_pkg::DIV_MY];
      out_touches_border   <= border_r;
      out_too_few_vertices <= few;
      out_zero_area        <= !few && (cross_sum_r == '0);
      out_count_overflow   <= overflow_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: verif/tb_polygon_area_centroid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polygon_area_centroid
// self-checking bench of the shoelace polygon area and centroid block
// ----------------------------------------------------------------------------
// vertex words are streamed polygon by polygon through the stall handshake,
// every accepted word runs through a local model of the accumulators and the
// fixed point divisions, and each result word is checked field by field
// against the oldest predicted word. directed shapes come first (triangles,
// both windings, degenerate, short, saturating, border and overflow cases),
// then random polygons under several image sizes, with random idle bursts on
// both sides and a calm stretch at the end.
// ----------------------------------------------------------------------------
module tb_polygon_area_centroid;

  localparam bit [63:0] FIX_SAT  = (64'd1 << pac_pkg::FIX_W) - 1;
  localparam bit [63:0] AREA_SAT = (64'd1 << pac_pkg::AREA_W) - 1;
  localparam int        DRAIN_CYCLES = 150;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [pac_pkg::COORD_W-1:0]   in_vertex_x;
  logic [pac_pkg::COORD_W-1:0]   in_vertex_y;
  logic                          in_last_vertex;
  logic                          out_valid;
  logic                          out_stall;
  logic [pac_pkg::AREA_W-1:0]    out_area_doubled;
  logic [pac_pkg::FIX_W-1:0]     out_centroid_x;
  logic [pac_pkg::FIX_W-1:0]     out_centroid_y;
  logic [pac_pkg::FIX_W-1:0]     out_mean_x;
  logic [pac_pkg::FIX_W-1:0]     out_mean_y;
  logic                          out_touches_border;
  logic                          out_too_few_vertices;
  logic                          out_zero_area;
  logic                          out_count_overflow;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [0:0]                    cfg_index;
  logic [pac_pkg::CFG_W-1:0]     cfg_data;

  // one predicted result word
  typedef struct {
    bit [pac_pkg::AREA_W-1:0] area_doubled;
    bit [pac_pkg::FIX_W-1:0]  centroid_x;
    bit [pac_pkg::FIX_W-1:0]  centroid_y;
    bit [pac_pkg::FIX_W-1:0]  mean_x;
    bit [pac_pkg::FIX_W-1:0]  mean_y;
    bit                       touches_border;
    bit                       too_few_vertices;
    bit                       zero_area;
    bit                       count_overflow;
  } shape_res_t;

  shape_res_t shape_q[$];

  // model copy of the config and of the polygon accumulators, 64-bit wrapping
  bit [63:0]   img_w, img_h;
  bit [63:0]   m_fx, m_fy, m_px, m_py;
  bit [63:0]   m_cross, m_cxs, m_cys, m_sumx, m_sumy;
  int unsigned m_count;
  bit          m_border, m_over;

  int errors;
  int words_sent;
  bit calm;      // no idling in the closing stretch

  polygon_area_centroid i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_vertex_x          (in_vertex_x),
    .in_vertex_y          (in_vertex_y),
    .in_last_vertex       (in_last_vertex),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_area_doubled     (out_area_doubled),
    .out_centroid_x       (out_centroid_x),
    .out_centroid_y       (out_centroid_y),
    .out_mean_x           (out_mean_x),
    .out_mean_y           (out_mean_y),
    .out_touches_border   (out_touches_border),
    .out_too_few_vertices (out_too_few_vertices),
    .out_zero_area        (out_zero_area),
    .out_count_overflow   (out_count_overflow),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #20ms;
    $display("tb_polygon_area_centroid failed");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic bit [63:0] magnitude(bit [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // signed n * 2^frac / d, clamped to [0, FIX_SAT]
  function automatic bit [63:0] fix_quot(bit [63:0] n, bit [63:0] d);
    bit [63:0] mn, md, q, r, res;
    mn = magnitude(n);
    md = magnitude(d);
    if (md == 0) return 0;
    if (mn != 0 && (n[63] != d[63])) return 0;   // negative centroid clamps
    q = mn / md;
    r = mn % md;
    if (q > (FIX_SAT >> pac_pkg::FRAC_BITS)) return FIX_SAT;
    res = (q << pac_pkg::FRAC_BITS) + ((r << pac_pkg::FRAC_BITS) / md);
    return (res > FIX_SAT) ? FIX_SAT : res;
  endfunction

  function automatic void add_segment(bit [63:0] ax, bit [63:0] ay,
                                      bit [63:0] bx, bit [63:0] by);
    bit [63:0] c;
    c = ax * by - bx * ay;
    m_cross += c;
    m_cxs   += (ax + bx) * c;
    m_cys   += (ay + by) * c;
  endfunction

  function automatic void clear_shape();
    m_fx = 0; m_fy = 0; m_px = 0; m_py = 0;
    m_cross = 0; m_cxs = 0; m_cys = 0; m_sumx = 0; m_sumy = 0;
    m_count = 0; m_border = 0; m_over = 0;
  endfunction

  // fold one accepted vertex word in, queue a result on the closing word
  function automatic void fold_vertex(bit [63:0] x, bit [63:0] y, bit last);
    shape_res_t r;
    bit [63:0]  a, mx, my;
    if (m_count < pac_pkg::MAX_VERTICES) begin
      if (x == 1 || y == 1 || x + 2 == img_w || y + 2 == img_h) m_border = 1;
      m_sumx += x;
      m_sumy += y;
      if (m_count == 0) begin
        m_fx = x;
        m_fy = y;
      end else begin
        add_segment(m_px, m_py, x, y);
      end
      m_px = x;
      m_py = y;
      m_count++;
    end else begin
      m_over = 1;
    end
    if (!last) return;
    if (m_count > 1) add_segment(m_px, m_py, m_fx, m_fy);
    r = '{default: 0};
    r.too_few_vertices = (m_count < 3);
    if (!r.too_few_vertices) begin
      a = magnitude(m_cross);
      r.area_doubled = pac_pkg::AREA_W'((a > AREA_SAT) ? AREA_SAT : a);
      r.zero_area = (m_cross == 0);
      if (!r.zero_area) begin
        r.centroid_x = pac_pkg::FIX_W'(fix_quot(m_cxs, m_cross * 3));
        r.centroid_y = pac_pkg::FIX_W'(fix_quot(m_cys, m_cross * 3));
      end
      mx = (m_sumx << pac_pkg::FRAC_BITS) / m_count;
      my = (m_sumy << pac_pkg::FRAC_BITS) / m_count;
      r.mean_x = pac_pkg::FIX_W'((mx > FIX_SAT) ? FIX_SAT : mx);
      r.mean_y = pac_pkg::FIX_W'((my > FIX_SAT) ? FIX_SAT : my);
    end
    r.touches_border = m_border;
    r.count_overflow = m_over;
    shape_q.insert(shape_q.size(), r);
    clear_shape();
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(string name, bit [63:0] exp, bit [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    shape_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (shape_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = shape_q.pop_front();
        check_field("area_doubled", 64'(e.area_doubled), 64'(out_area_doubled));
        check_field("centroid_x", 64'(e.centroid_x), 64'(out_centroid_x));
        check_field("centroid_y", 64'(e.centroid_y), 64'(out_centroid_y));
        check_field("mean_x", 64'(e.mean_x), 64'(out_mean_x));
        check_field("mean_y", 64'(e.mean_y), 64'(out_mean_y));
        check_field("touches_border", 64'(e.touches_border), 64'(out_touches_border));
        check_field("too_few_vertices", 64'(e.too_few_vertices),
                    64'(out_too_few_vertices));
        check_field("zero_area", 64'(e.zero_area), 64'(out_zero_area));
        check_field("count_overflow", 64'(e.count_overflow), 64'(out_count_overflow));
      end
    end
  end

  // receiver backpressure in random bursts, with open stretches between
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // called just after a rising edge, returns just after the accepting edge
  task automatic send_vertex(int x, int y, bit last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_vertex_x    <= pac_pkg::COORD_W'(x);
    in_vertex_y    <= pac_pkg::COORD_W'(y);
    in_last_vertex <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_vertex(64'(x), 64'(y), last);
    words_sent++;
  endtask

  task automatic send_polygon(int xs[$], int ys[$]);
    foreach (xs[i]) send_vertex(xs[i], ys[i], i == xs.size() - 1);
  endtask

  // all results in, then let the divider settle before touching config
  task automatic drain();
    in_valid <= 1'b0;
    while (shape_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high, the caller drops it after the last write
  task automatic write_cfg(pac_pkg::cfg_reg_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= pac_pkg::CFG_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == pac_pkg::CFG_IMAGE_WIDTH) img_w = 64'(value);
    else img_h = 64'(value);
  endtask

  task automatic set_image(int w, int h);
    drain();
    write_cfg(pac_pkg::CFG_IMAGE_WIDTH, w);
    write_cfg(pac_pkg::CFG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  // basic shapes at reset sizes: windings, degenerate, short, extremes
  task automatic test_shapes();
    send_polygon('{10, 50, 20}, '{10, 10, 40});                 // ccw triangle
    send_polygon('{10, 20, 50}, '{10, 40, 10});                 // cw triangle
    send_polygon('{0, 4095, 4095, 0}, '{0, 0, 4095, 4095});     // full square
    send_polygon('{5, 10, 15, 20}, '{5, 10, 15, 20});           // collinear, zero area
    send_polygon('{4095}, '{4095});                             // single vertex
    send_polygon('{100, 200}, '{300, 400});                     // two vertices
    // square wound three times, area saturates
    send_polygon('{0, 4095, 4095, 0, 0, 4095, 4095, 0, 0, 4095, 4095, 0},
                 '{0, 0, 4095, 4095, 0, 0, 4095, 4095, 0, 0, 4095, 4095});
  endtask

  // border hits on each side, under the smallest and largest sizes
  task automatic test_border();
    set_image(4, 4096);
    send_polygon('{2, 3, 3}, '{3, 3, 3000});      // x == width-2
    send_polygon('{1, 40, 40}, '{30, 30, 60});    // x == 1
    send_polygon('{30, 40, 40}, '{1, 30, 60});    // y == 1
    set_image(4096, 4);
    send_polygon('{30, 4094, 40}, '{2, 30, 60});  // x == width-2, y == height-2
    send_polygon('{30, 40, 50}, '{3, 30, 60});    // no hit
    set_image(4096, 4096);
    send_polygon('{30, 4000, 40}, '{4094, 30, 60});
  endtask

  // more vertices than the block holds, closed by an ignored word
  task automatic test_overflow();
    int xs[$], ys[$];
    for (int i = 0; i < pac_pkg::MAX_VERTICES + 4; i++) begin
      xs.insert(xs.size(), $urandom_range(0, 4095));
      ys.insert(ys.size(), $urandom_range(0, 4095));
    end
    calm = 1'b1;   // long run, keep it quick
    send_polygon(xs, ys);
    calm = 1'b0;
    send_polygon('{10, 50, 20}, '{10, 10, 40});   // flag must not linger
  endtask

  function automatic int rand_coord(int mode);
    case (mode)
      0: return $urandom_range(0, 4095);
      1: return $urandom_range(0, 63);
      default: begin
        case ($urandom_range(0, 4))
          0: return 0;
          1: return 1;
          2: return (img_w >= 2) ? int'(img_w - 2) & 12'hfff : 0;
          3: return 4095;
          default: return $urandom_range(0, 4095);
        endcase
      end
    endcase
  endfunction

  // random polygons, mostly well formed, some short, some long
  task automatic test_random();
    int xs[$], ys[$];
    int n, mode, stop, k;
    k = 0;
    stop = words_sent + 700;
    while (words_sent < stop) begin
      if (k % 15 == 14) begin
        case ($urandom_range(0, 3))
          0: set_image(4, 4);
          1: set_image(4096, 4096);
          default: set_image($urandom_range(4, 4096), $urandom_range(4, 4096));
        endcase
      end
      if (words_sent > stop - 100) calm = 1'b1;
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(1, 2);
        1:       n = $urandom_range(20, 40);
        default: n = $urandom_range(3, 10);
      endcase
      mode = $urandom_range(0, 2);
      xs.delete();
      ys.delete();
      repeat (n) begin
        xs.insert(xs.size(), rand_coord(mode));
        ys.insert(ys.size(), rand_coord(mode));
      end
      send_polygon(xs, ys);
      k++;
    end
  endtask

  initial begin
    in_valid       = 1'b0;
    in_vertex_x    = '0;
    in_vertex_y    = '0;
    in_last_vertex = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = pac_pkg::CFG_IMAGE_WIDTH;
    cfg_data       = '0;
    rst_n          = 1'b0;
    errors         = 0;
    words_sent     = 0;
    calm           = 1'b0;
    img_w          = 1024;
    img_h          = 768;
    clear_shape();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_shapes();
    test_border();
    test_overflow();
    test_random();
    drain();

    if (errors == 0) begin
      $display("tb_polygon_area_centroid passed");
    end else begin
      $display("tb_polygon_area_centroid failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pac_pkg.sv
rtl/pac_ctrl.sv
rtl/pac_datapath.sv
rtl/polygon_area_centroid.sv
verif/tb_polygon_area_centroid.sv
